>>> hw/rtl/fvns_pkg.sv
// Shared types, codes and constant tables for the four-voice note sequencer.
`timescale 1ns / 1ps

package fvns_pkg;

    localparam int START_W   = 11;
    localparam int START_NUM = 4;
    localparam int REG_IDX_W = 2;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    localparam logic [1:0] DRUM_KICK  = 2'd0;
    localparam logic [1:0] DRUM_SNARE = 2'd1;
    localparam logic [1:0] DRUM_HIHAT = 2'd2;

    localparam logic [7:0] NOTE_REST  = 8'd0;
    localparam logic [7:0] NOTE_KICK  = 8'd1;
    localparam logic [7:0] NOTE_SNARE = 8'd2;

    localparam logic [7:0] PAN_CENTRE = 8'd128;

    localparam logic [1:0] REG_VOICE0 = 2'd0;
    localparam logic [1:0] REG_VOICE1 = 2'd1;
    localparam logic [1:0] REG_VOICE2 = 2'd2;
    localparam logic [1:0] REG_DRUM   = 2'd3;

    typedef struct packed {
        logic        cmd;
        logic [10:0] load_address;
        logic [7:0]  load_word;
    } req_t;

    typedef struct packed {
        logic [1:0] voice;
        logic       play;
        logic [7:0] note;
        logic [1:0] drum_kind;
        logic [7:0] pan;
        logic       last;
    } rsp_t;

    typedef enum logic {
        AOP_OFFSET,
        AOP_REDUCE
    } addr_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_NOTE,
        ST_DUR,
        ST_WRAP,
        ST_PUSH,
        ST_FLUSH
    } seq_state_t;

    function automatic logic [7:0] melodic_pan(input logic [1:0] idx);
        logic [7:0] p;
        case (idx)
            2'd0:    p = 8'd128;
            2'd1:    p = 8'd224;
            2'd2:    p = 8'd32;
            default: p = PAN_CENTRE;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] drum_pan(input logic [1:0] kind);
        logic [7:0] p;
        case (kind)
            DRUM_KICK:  p = 8'd128;
            DRUM_SNARE: p = 8'd160;
            default:    p = 8'd96;
        endcase
        return p;
    endfunction

endpackage

>>> hw/rtl/fvns_song_mem.sv
// Song word memory: one address port, registered read data.
`timescale 1ns / 1ps

module fvns_song_mem #(
    parameter int SONG_DEPTH = 2048,
    parameter int AW         = 11
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [7:0]    wdata,
    output logic [7:0]    rdata
);

    logic [7:0] mem [SONG_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/fvns_addr_unit.sv
// Shared address unit: position plus small offset with wrap, or reduction modulo depth.
`timescale 1ns / 1ps

module fvns_addr_unit #(
    parameter int SONG_DEPTH = 2048,
    parameter int AW         = 11
) (
    input  fvns_pkg::addr_op_t op,
    input  logic [AW-1:0]      base,
    input  logic [1:0]         offset,
    input  logic [10:0]        raw,
    output logic [AW-1:0]      result
);

    import fvns_pkg::*;

    // depth is at least 64, so five halving steps cover any 11-bit value
    localparam int RW = AW + 5;

    logic [AW:0]   sum;
    logic [RW-1:0] rem;

    always_comb
    begin
        sum = {1'b0, base} + (AW + 1)'(offset);
        if (sum >= (AW + 1)'(SONG_DEPTH))
        begin
            sum = sum - (AW + 1)'(SONG_DEPTH);
        end

        rem = RW'(raw);
        for (int k = 4; k >= 0; k--)
        begin
            if (rem >= (RW'(SONG_DEPTH) << k))
            begin
                rem = rem - (RW'(SONG_DEPTH) << k);
            end
        end

        case (op)
            AOP_OFFSET: result = sum[AW-1:0];
            AOP_REDUCE: result = rem[AW-1:0];
            default:    result = sum[AW-1:0];
        endcase
    end

endmodule

>>> hw/rtl/fvns_ctrl.sv
// Sequencer: walks the voices on a tick, drives memory and address unit, holds the result words.
`timescale 1ns / 1ps

module fvns_ctrl #(
    parameter int VOICE_COUNT = 4,
    parameter int AW          = 11
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  fvns_pkg::req_t      req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output fvns_pkg::rsp_t      rsp,
    input  logic [fvns_pkg::START_NUM-1:0][fvns_pkg::START_W-1:0] starts,
    output fvns_pkg::addr_op_t  au_op,
    output logic [AW-1:0]       au_base,
    output logic [1:0]          au_offset,
    output logic [10:0]         au_raw,
    input  logic [AW-1:0]       au_result,
    output logic                mem_we,
    output logic [AW-1:0]       mem_addr,
    output logic [7:0]          mem_wdata,
    input  logic [7:0]          mem_rdata
);

    import fvns_pkg::*;

    localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam logic [VW-1:0] LAST_VOICE = VW'(VOICE_COUNT - 1);

    seq_state_t    state_reg, state_next;
    logic [VW-1:0] v_reg, v_next;
    logic [AW-1:0] pos_reg [VOICE_COUNT];
    logic [AW-1:0] pos_next [VOICE_COUNT];
    logic [7:0]    rem_reg [VOICE_COUNT];
    logic [7:0]    rem_next [VOICE_COUNT];
    logic [7:0]    note_reg, note_next;
    rsp_t          evt_reg, evt_next;
    rsp_t          pend_reg, pend_next;
    logic          pend_valid_reg, pend_valid_next;
    rsp_t          out_reg, out_next;
    logic          out_valid_reg, out_valid_next;

    logic          out_free;
    logic          advance;
    logic [10:0]   voice_start;
    logic [1:0]    kind;
    logic [1:0]    v_idx;

    assign out_free  = !out_valid_reg || !rsp_stall;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;
    assign req_stall = (state_reg != ST_IDLE);
    assign v_idx     = 2'(v_reg);

    always_comb
    begin
        if (v_reg == LAST_VOICE)
        begin
            voice_start = starts[REG_DRUM];
        end
        else if (int'(v_reg) < 3)
        begin
            voice_start = starts[v_idx];
        end
        else
        begin
            voice_start = '0;
        end

        case (note_reg)
            NOTE_KICK:  kind = DRUM_KICK;
            NOTE_SNARE: kind = DRUM_SNARE;
            default:    kind = DRUM_HIHAT;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        v_next          = v_reg;
        pos_next        = pos_reg;
        rem_next        = rem_reg;
        note_next       = note_reg;
        evt_next        = evt_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && rsp_stall;
        advance         = 1'b0;

        au_op     = AOP_OFFSET;
        au_base   = pos_reg[v_reg];
        au_offset = 2'd0;
        au_raw    = req.load_address;
        mem_we    = 1'b0;
        mem_addr  = au_result;
        mem_wdata = req.load_word;

        case (state_reg)
            ST_IDLE:
            begin
                au_op = AOP_REDUCE;
                if (req_valid)
                begin
                    if (req.cmd == CMD_LOAD)
                    begin
                        mem_we = 1'b1;
                    end
                    else
                    begin
                        v_next     = '0;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (rem_reg[v_reg] == 8'd0)
                begin
                    state_next = ST_NOTE;
                end
                else
                begin
                    rem_next[v_reg] = rem_reg[v_reg] - 8'd1;
                    advance         = 1'b1;
                end
            end
            ST_NOTE:
            begin
                note_next  = mem_rdata;
                au_offset  = 2'd1;
                state_next = ST_DUR;
            end
            ST_DUR:
            begin
                // load the countdown and take this tick's decrement at once
                rem_next[v_reg] = (mem_rdata == 8'd0) ? 8'd0 : mem_rdata - 8'd1;
                au_offset       = 2'd3;
                state_next      = ST_WRAP;
            end
            ST_WRAP:
            begin
                if (mem_rdata == 8'd0)
                begin
                    au_op  = AOP_REDUCE;
                    au_raw = voice_start;
                end
                else
                begin
                    au_offset = 2'd2;
                end
                pos_next[v_reg] = au_result;

                evt_next.voice = v_idx;
                evt_next.note  = note_reg;
                evt_next.last  = 1'b0;
                if (v_reg == LAST_VOICE)
                begin
                    evt_next.play      = 1'b1;
                    evt_next.drum_kind = kind;
                    evt_next.pan       = drum_pan(kind);
                end
                else
                begin
                    evt_next.play      = (note_reg != NOTE_REST);
                    evt_next.drum_kind = DRUM_KICK;
                    evt_next.pan       = (int'(v_reg) < 3) ? melodic_pan(v_idx) : PAN_CENTRE;
                end
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                // hold the newest word back until the tick shows whether it is the last
                if (!pend_valid_reg)
                begin
                    pend_next       = evt_reg;
                    pend_valid_next = 1'b1;
                    advance         = 1'b1;
                end
                else if (out_free)
                begin
                    out_next        = pend_reg;
                    out_valid_next  = 1'b1;
                    pend_next       = evt_reg;
                    advance         = 1'b1;
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_next        = pend_reg;
                    out_next.last   = 1'b1;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (advance)
        begin
            if (v_reg == LAST_VOICE)
            begin
                state_next = pend_valid_next ? ST_FLUSH : ST_IDLE;
            end
            else
            begin
                v_next     = v_reg + 1'b1;
                state_next = ST_CHECK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            v_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < VOICE_COUNT; i++)
            begin
                pos_reg[i] <= '0;
                rem_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            v_reg          <= v_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            pos_reg        <= pos_next;
            rem_reg        <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        note_reg <= note_next;
        evt_reg  <= evt_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

endmodule

>>> hw/rtl/four_voice_note_sequencer_unit.sv
// Top level of the four-voice note sequencer: start registers and module wiring.
`timescale 1ns / 1ps

// A load word writes one song word. A tick walks the voices in order under one
// sequencer: a voice that is not due only has its countdown decremented; a due
// voice makes three reads of the single song memory port through the shared
// address unit, then hands over its event word. The final word of the tick is
// released at its end, later while the result side stalls. The request side
// stalls for the whole of a tick. Event words come out in voice order and the
// final one of each tick carries last. Start register writes move no read
// position; a new start takes effect at the voice's next loop wrap.
module four_voice_note_sequencer_unit #(
    parameter int SONG_DEPTH  = 2048,
    parameter int VOICE_COUNT = 4
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    output logic                                  req_stall,
    input  fvns_pkg::req_t                        req,
    output logic                                  rsp_valid,
    input  logic                                  rsp_stall,
    output fvns_pkg::rsp_t                        rsp,
    input  logic                                  wr_en,
    input  logic [fvns_pkg::REG_IDX_W-1:0]        wr_index,
    input  logic [fvns_pkg::START_W-1:0]          wr_data
);

    import fvns_pkg::*;

    localparam int AW = $clog2(SONG_DEPTH);

    logic [START_NUM-1:0][START_W-1:0] start_reg;

    addr_op_t      au_op;
    logic [AW-1:0] au_base;
    logic [1:0]    au_offset;
    logic [10:0]   au_raw;
    logic [AW-1:0] au_result;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;
    logic [7:0]    mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
        end
        else if (wr_en)
        begin
            start_reg[wr_index] <= wr_data;
        end
    end

    fvns_addr_unit #(
        .SONG_DEPTH (SONG_DEPTH),
        .AW         (AW)
    ) u_addr (
        .op     (au_op),
        .base   (au_base),
        .offset (au_offset),
        .raw    (au_raw),
        .result (au_result)
    );

    fvns_song_mem #(
        .SONG_DEPTH (SONG_DEPTH),
        .AW         (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    fvns_ctrl #(
        .VOICE_COUNT (VOICE_COUNT),
        .AW          (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .starts    (start_reg),
        .au_op     (au_op),
        .au_base   (au_base),
        .au_offset (au_offset),
        .au_raw    (au_raw),
        .au_result (au_result),
        .mem_we    (mem_we),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

endmodule
